>>> hw/rtl/pss_pkg.sv
`default_nettype none
package pss_pkg;

   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_PLUCK = 2'd1;
   localparam logic [1:0] FUNC_LOAD  = 2'd2;

   localparam logic [1:0] CSR_STRING_LENGTH = 2'd0;
   localparam logic [1:0] CSR_DECAY_Q16     = 2'd1;
   localparam logic [1:0] CSR_NOISE_SEED    = 2'd2;

   localparam logic [10:0] STRING_LENGTH_RESET = 11'd100;
   localparam logic [15:0] DECAY_Q16_RESET     = 16'd65274;
   localparam logic [15:0] NOISE_SEED_RESET    = 16'd44257;

   localparam logic [15:0] LFSR_TAPS = 16'hB400;

   typedef struct packed {
      logic [10:0] string_length;
      logic [15:0] decay_q16;
      logic [15:0] noise_seed;
   } cfg_type;

   function automatic logic [15:0] lfsr_step(input logic [15:0] state);
      logic [15:0] shifted;
      shifted = {1'b0, state[15:1]};
      if (state[0]) begin
         shifted = shifted ^ LFSR_TAPS;
      end
      return shifted;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/pss_csr.sv
`default_nettype none
module pss_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [1:0]      csr_index,
   input  wire logic [15:0]     csr_wdata,
   output pss_pkg::cfg_type     cfg
);
   import pss_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_STRING_LENGTH: cfg_in.string_length = csr_wdata[10:0];
            CSR_DECAY_Q16:     cfg_in.decay_q16     = csr_wdata;
            CSR_NOISE_SEED:    cfg_in.noise_seed    = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.string_length <= STRING_LENGTH_RESET;
         cfg_ff.decay_q16     <= DECAY_Q16_RESET;
         cfg_ff.noise_seed    <= NOISE_SEED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

>>> hw/rtl/pss_line_mem.sv
`default_nettype none
module pss_line_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [15:0]       wr_data,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output logic [15:0]            rd_data
);

   logic [15:0] mem_ff [DEPTH];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hw/rtl/pss_decay.sv
`default_nettype none
module pss_decay (
   input  wire logic               clock,
   input  wire logic signed [15:0] sample_a,
   input  wire logic signed [15:0] sample_b,
   input  wire logic [15:0]        decay_q16,
   output logic signed [15:0]      result
);

   logic signed [16:0] pair_sum;
   logic signed [33:0] product_in;
   logic signed [33:0] product_ff;
   logic signed [33:0] biased;

   assign pair_sum   = 17'(sample_a) + 17'(sample_b);
   assign product_in = $signed({1'b0, decay_q16}) * pair_sum;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   // truncate toward zero: bias negatives before the arithmetic shift
   assign biased = product_ff[33] ? product_ff + 34'sd131071 : product_ff;
   assign result = 16'(biased >>> 17);

endmodule
`default_nettype wire

>>> hw/rtl/plucked_string_synth.sv
`default_nettype none
// Plucked-string synthesizer over a circular delay line held in one RAM.
// req channel: req_func selects tick, pluck, load or no-op; req_load_value is the
// sample appended by a load. Every word returns one rsp word with the head
// sample, the running tick count and an error flag.
// csr channel: register index and write data, always ready; index 0 is the
// string length, 1 the decay factor, 2 the noise seed.
// Steps per req: a tick reads the next sample, runs the registered multiply
// and writes the result back; a pluck makes one RAM write per sample of the
// effective length; a load or no-op goes straight to the finish state.
// One word is worked on at a time; the next req is taken as soon as the
// sequencer is idle, while the previous rsp may still wait in its register.
// The RAM has a single write port and a single read port.
// Reset empties the line, clears the tick count and restores the register
// defaults; RAM contents are not cleared and need no clearing pass.
// A stalled rsp holds its word; the finished word waits in the sequencer
// until the output register is free, and no req is taken meanwhile.
module plucked_string_synth #(
   parameter int MAX_LENGTH = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic signed [15:0] req_load_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [15:0] rsp_head_sample,
   output logic [31:0]      rsp_tick_count,
   output logic             rsp_error,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import pss_pkg::*;

   localparam int AW = $clog2(MAX_LENGTH);
   localparam int LW = $clog2(MAX_LENGTH + 1);
   localparam int CW = (LW > 11) ? LW : 11;
   localparam logic [CW-1:0] MAX_C   = CW'(MAX_LENGTH);
   localparam logic [LW:0]   MAX_W   = (LW+1)'(MAX_LENGTH);
   localparam logic [AW-1:0] LAST_AD = AW'(MAX_LENGTH - 1);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_TICK_MUL = 3'd1;
   localparam logic [2:0] ST_TICK_WR  = 3'd2;
   localparam logic [2:0] ST_PLUCK    = 3'd3;
   localparam logic [2:0] ST_FIN      = 3'd4;

   cfg_type cfg;

   logic [2:0]         state_ff, state_in;
   logic [AW-1:0]      head_ff, head_in;
   logic [LW-1:0]      fill_ff, fill_in;
   logic [31:0]        tick_total_ff, tick_total_in;
   logic [15:0]        lfsr_ff, lfsr_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic signed [15:0] head_val_ff, head_val_in;
   logic               err_ff, err_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_head_ff, rsp_head_in;
   logic [31:0]        rsp_tick_ff, rsp_tick_in;
   logic               rsp_error_ff, rsp_error_in;

   logic               mem_wr_en;
   logic [AW-1:0]      mem_wr_addr;
   logic [15:0]        mem_wr_data;
   logic               mem_rd_en;
   logic [15:0]        mem_rd_data;
   logic signed [15:0] decayed;

   logic [CW-1:0]      len_ext;
   logic [LW-1:0]      eff_len;
   logic [LW:0]        tail_sum;
   logic [AW-1:0]      tail_addr;
   logic [AW-1:0]      head_next;
   logic [15:0]        lfsr_next;
   logic               req_fire;
   logic               rsp_free;

   pss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pss_line_mem #(
      .DEPTH (MAX_LENGTH),
      .AW    (AW)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (head_next),
      .rd_data (mem_rd_data)
   );

   pss_decay u_decay (
      .clock     (clock),
      .sample_a  (head_val_ff),
      .sample_b  ($signed(mem_rd_data)),
      .decay_q16 (cfg.decay_q16),
      .result    (decayed)
   );

   // effective length, clamped to 2..MAX_LENGTH
   always_comb begin
      len_ext = CW'(cfg.string_length);
      if (len_ext < CW'(2)) begin
         eff_len = LW'(2);
      end else if (len_ext > MAX_C) begin
         eff_len = LW'(MAX_LENGTH);
      end else begin
         eff_len = LW'(len_ext);
      end
   end

   assign tail_sum  = (LW+1)'(head_ff) + (LW+1)'(fill_ff);
   assign tail_addr = (tail_sum >= MAX_W) ? AW'(tail_sum - MAX_W) : AW'(tail_sum);
   assign head_next = (head_ff == LAST_AD) ? '0 : head_ff + AW'(1);
   assign lfsr_next = lfsr_step(lfsr_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign mem_rd_en = req_fire && (req_func == FUNC_TICK) && (fill_ff >= LW'(2));

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      tick_total_in = tick_total_ff;
      lfsr_in       = lfsr_ff;
      idx_in        = idx_ff;
      head_val_in   = head_val_ff;
      err_in        = err_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_head_in   = rsp_head_ff;
      rsp_tick_in   = rsp_tick_ff;
      rsp_error_in  = rsp_error_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = tail_addr;
      mem_wr_data   = 16'(decayed);

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               err_in   = 1'b0;
               state_in = ST_FIN;
               case (req_func)
                  FUNC_TICK: begin
                     if (fill_ff < LW'(2)) begin
                        err_in = 1'b1;
                     end else begin
                        state_in = ST_TICK_MUL;
                     end
                  end
                  FUNC_PLUCK: begin
                     head_in  = '0;
                     fill_in  = '0;
                     idx_in   = '0;
                     lfsr_in  = (cfg.noise_seed != 16'd0) ? cfg.noise_seed : 16'd1;
                     state_in = ST_PLUCK;
                  end
                  FUNC_LOAD: begin
                     if (fill_ff >= eff_len) begin
                        err_in = 1'b1;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = req_load_value;
                        fill_in     = fill_ff + LW'(1);
                        if (fill_ff == '0) begin
                           head_val_in = req_load_value;
                        end
                     end
                  end
                  default: begin
                     state_in = ST_FIN;
                  end
               endcase
            end
         end
         ST_TICK_MUL: begin
            // next sample becomes the head; the old head still feeds the multiply
            head_val_in = $signed(mem_rd_data);
            state_in    = ST_TICK_WR;
         end
         ST_TICK_WR: begin
            mem_wr_en     = 1'b1;
            head_in       = head_next;
            tick_total_in = tick_total_ff + 32'd1;
            state_in      = ST_FIN;
         end
         ST_PLUCK: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = idx_ff;
            mem_wr_data = lfsr_next;
            lfsr_in     = lfsr_next;
            idx_in      = idx_ff + AW'(1);
            if (idx_ff == '0) begin
               head_val_in = $signed(lfsr_next);
            end
            if (LW'(idx_ff) == eff_len - LW'(1)) begin
               fill_in  = eff_len;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_head_in  = (fill_ff != '0) ? head_val_ff : 16'sd0;
               rsp_tick_in  = tick_total_ff;
               rsp_error_in = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         fill_ff       <= '0;
         tick_total_ff <= '0;
         lfsr_ff       <= NOISE_SEED_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         fill_ff       <= fill_in;
         tick_total_ff <= tick_total_in;
         lfsr_ff       <= lfsr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      head_val_ff  <= head_val_in;
      err_ff       <= err_in;
      rsp_head_ff  <= rsp_head_in;
      rsp_tick_ff  <= rsp_tick_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_head_sample = rsp_head_ff;
   assign rsp_tick_count  = rsp_tick_ff;
   assign rsp_error       = rsp_error_ff;

   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LW'(MAX_LENGTH))
      else $error("fill count beyond line depth");

   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("accepted word did not start work");

   assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_TICK_WR |=> $stable(tick_total_ff))
      else $error("tick count moved outside write-back");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PLUCK |-> lfsr_ff != 16'd0)
      else $error("noise register stuck at zero");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN && rsp_free |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("finished word not moved to output register");

endmodule
`default_nettype wire

>>> bench/plucked_string_synth_tb.sv
module plucked_string_synth_tb;
   import pss_pkg::*;

   localparam int LINE_DEPTH = 1024;
   localparam logic [1:0] FUNC_NOP = 2'd3;

   typedef struct {
      logic signed [15:0] head_sample;
      logic [31:0]        tick_count;
      logic               error;
   } string_result_type;

   class pluck_scoreboard;
      logic signed [15:0] line [LINE_DEPTH];
      logic [9:0]         head;
      logic [10:0]        fill;
      logic [31:0]        ticks;
      logic [15:0]        lfsr;
      logic [10:0]        length_reg;
      logic [15:0]        decay;
      logic [15:0]        seed;
      string_result_type  expected_words[$];
      int                 mismatch_count;

      function new();
         head = '0;
         fill = '0;
         ticks = '0;
         length_reg = STRING_LENGTH_RESET;
         decay = DECAY_Q16_RESET;
         seed = NOISE_SEED_RESET;
         lfsr = NOISE_SEED_RESET;
         mismatch_count = 0;
      endfunction

      function int eff_length();
         if (length_reg < 11'd2) begin
            return 2;
         end
         if (length_reg > 11'(LINE_DEPTH)) begin
            return LINE_DEPTH;
         end
         return int'(length_reg);
      endfunction

      function bit has_room();
         return int'(fill) < eff_length();
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function void set_reg(logic [1:0] idx, logic [15:0] val);
         case (idx)
            CSR_STRING_LENGTH: length_reg = val[10:0];
            CSR_DECAY_Q16: decay = val;
            CSR_NOISE_SEED: seed = val;
            default: ;
         endcase
      endfunction

      // work out the word the block must return for an accepted request
      function void note_word(logic [1:0] f, logic signed [15:0] v);
         string_result_type r;
         logic signed [15:0] a;
         logic signed [15:0] b;
         int sum;
         int n;
         longint d;
         longint p;
         longint q;
         r.error = 1'b0;
         case (f)
            FUNC_TICK: begin
               if (fill < 11'd2) begin
                  r.error = 1'b1;
               end else begin
                  a = line[head];
                  b = line[head + 10'd1];
                  sum = a + b;
                  d = decay;
                  p = d * sum;
                  // truncate toward zero
                  q = (p < 0) ? -((-p) >>> 17) : (p >>> 17);
                  line[head + fill[9:0]] = q[15:0];
                  head = head + 10'd1;
                  ticks = ticks + 32'd1;
               end
            end
            FUNC_PLUCK: begin
               n = eff_length();
               head = '0;
               lfsr = (seed != 16'd0) ? seed : 16'd1;
               for (int i = 0; i < n; i++) begin
                  lfsr = {1'b0, lfsr[15:1]} ^ (lfsr[0] ? LFSR_TAPS : 16'h0000);
                  line[i] = lfsr;
               end
               fill = 11'(n);
            end
            FUNC_LOAD: begin
               if (!has_room()) begin
                  r.error = 1'b1;
               end else begin
                  line[head + fill[9:0]] = v;
                  fill = fill + 11'd1;
               end
            end
            default: ;
         endcase
         r.head_sample = (fill != 11'd0) ? line[head] : 16'sd0;
         r.tick_count = ticks;
         expected_words.push_back(r);
      endfunction

      task report_mismatch(string msg);
         $display("mismatch: %s", msg);
         mismatch_count++;
      endtask

      task check_word(logic signed [15:0] hs, logic [31:0] tc, logic e);
         string_result_type x;
         if (expected_words.size() == 0) begin
            report_mismatch("response word with nothing expected");
            return;
         end
         x = expected_words.pop_front();
         if (hs !== x.head_sample) begin
            report_mismatch($sformatf("head_sample got %0d expected %0d", hs, x.head_sample));
         end
         if (tc !== x.tick_count) begin
            report_mismatch($sformatf("tick_count got %0d expected %0d", tc, x.tick_count));
         end
         if (e !== x.error) begin
            report_mismatch($sformatf("error got %0b expected %0b", e, x.error));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [1:0] req_func;
   logic signed [15:0] req_load_value;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [15:0] rsp_head_sample;
   logic [31:0] rsp_tick_count;
   logic rsp_error;
   logic csr_valid;
   logic csr_ready;
   logic [1:0] csr_index;
   logic [15:0] csr_wdata;

   pluck_scoreboard sb = new();
   bit calm;
   bit hold_req;

   plucked_string_synth uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_load_value(req_load_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_head_sample(rsp_head_sample),
      .rsp_tick_count(rsp_tick_count),
      .rsp_error(rsp_error),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // valid stays high across back-to-back words; it drops only for a gap or a settle
   task automatic send_word(input logic [1:0] f, input logic signed [15:0] v);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 18);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_load_value <= v;
      do @(posedge clock); while (!req_ready);
      sb.note_word(f, v);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, val);
   endtask

   task automatic set_config(input logic [10:0] len, input logic [15:0] dec,
                             input logic [15:0] sd);
      // upper bits of the length word are don't-care
      write_reg(CSR_STRING_LENGTH, {5'($urandom()), len});
      write_reg(CSR_DECAY_Q16, dec);
      write_reg(CSR_NOISE_SEED, sd);
      csr_valid <= 1'b0;
   endtask

   initial begin : drain
      int stall;
      stall = 0;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            sb.check_word(rsp_head_sample, rsp_tick_count, rsp_error);
            if (hold_req) begin
               // long back-pressure so the block fills and stalls its input
               stall = 300;
               hold_req = 1'b0;
            end else begin
               stall = calm ? 0 : $urandom_range(0, 18);
            end
            if (stall != 0) begin
               rsp_ready <= 1'b0;
            end
         end else if (!rsp_ready) begin
            if (stall > 0) begin
               stall--;
            end
            if (stall == 0) begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   initial begin : stimulus
      int ph;
      int k;
      int r;
      logic [10:0] len;
      logic [15:0] dec;
      logic [15:0] sd;
      logic [1:0] f;
      logic signed [15:0] v;
      calm = 1'b0;
      hold_req = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_func <= FUNC_TICK;
      req_load_value <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_STRING_LENGTH;
      csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty and one-entry ticks, extreme sums, no-op, full-line load
      send_word(FUNC_TICK, 16'sd0);
      send_word(FUNC_LOAD, 16'sh7FFF);
      send_word(FUNC_TICK, 16'sd0);
      send_word(FUNC_LOAD, 16'sh7FFF);
      send_word(FUNC_LOAD, 16'sh8000);
      send_word(FUNC_LOAD, 16'sh8000);
      send_word(FUNC_TICK, 16'sh7FFF);
      send_word(FUNC_TICK, 16'sh8000);
      send_word(FUNC_TICK, 16'sd0);
      send_word(FUNC_NOP, 16'sh7FFF);
      send_word(FUNC_PLUCK, 16'sd0);
      send_word(FUNC_TICK, 16'sd0);
      send_word(FUNC_LOAD, 16'sh5555);

      // length below range saturates; line now longer than the length
      settle();
      set_config(11'd0, 16'hFFFF, 16'h0000);
      send_word(FUNC_TICK, 16'sd0);
      send_word(FUNC_LOAD, 16'shAAAA);
      send_word(FUNC_PLUCK, 16'sd0);
      send_word(FUNC_TICK, 16'sd0);

      // length above range saturates to the full line
      settle();
      set_config(11'h7FF, 16'h0000, 16'hFFFF);
      send_word(FUNC_PLUCK, 16'sd0);
      send_word(FUNC_TICK, 16'sd0);
      send_word(FUNC_LOAD, 16'sh7FFF);

      settle();
      set_config(11'd2, 16'hFFFF, 16'h0001);
      send_word(FUNC_PLUCK, 16'sd0);
      send_word(FUNC_TICK, 16'sd0);

      for (ph = 0; ph < 12; ph++) begin
         settle();
         case ($urandom_range(0, 5))
            0: len = 11'($urandom());
            1: len = 11'($urandom_range(0, 3));
            default: len = 11'($urandom_range(2, 48));
         endcase
         if (ph == 7) begin
            len = 11'd1024;
         end
         case ($urandom_range(0, 5))
            0: dec = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            1: dec = 16'($urandom());
            default: dec = 16'($urandom_range(60000, 65535));
         endcase
         sd = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom());
         set_config(len, dec, sd);
         calm = (ph == 4) || ($urandom_range(0, 3) == 0);
         for (k = 0; k < 82; k++) begin
            if (ph == 4 && k == 30) begin
               hold_req = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 4) begin
               f = FUNC_PLUCK;
            end else if (r < 7) begin
               f = FUNC_NOP;
            end else if (r < 20 || (sb.has_room() && r < 65)) begin
               f = FUNC_LOAD;
            end else begin
               f = FUNC_TICK;
            end
            v = 16'($urandom());
            if ($urandom_range(0, 7) == 0) begin
               v = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            end
            send_word(f, v);
         end
      end

      settle();
      calm = 1'b0;
      repeat (40) @(posedge clock);
      if (sb.mismatch_count == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/pss_pkg.sv
hw/rtl/pss_csr.sv
hw/rtl/pss_line_mem.sv
hw/rtl/pss_decay.sv
hw/rtl/plucked_string_synth.sv
bench/plucked_string_synth_tb.sv
